// ===== rtl/batch_priority_flush_buffer_assert.svh =====
// assertion macros for the batch priority flush buffer checker
`ifndef BATCH_PRIORITY_FLUSH_BUFFER_ASSERT_SVH
`define BATCH_PRIORITY_FLUSH_BUFFER_ASSERT_SVH

// checked outside reset, antecedent and consequent on the same edge
`define BPFB_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("bpfb assertion failed");

// checked outside reset, consequent on the following edge
`define BPFB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("bpfb assertion failed");

// checked at every edge, reset included
`define BPFB_ASSERT_NEXT_ALWAYS(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error("bpfb assertion failed");

`endif

// ===== rtl/bpfb_pkg.sv =====
`default_nettype none

package bpfb_pkg;

    localparam int SOCK_W   = 16;
    localparam int PRIO_W   = 8;
    localparam int PHOTO_W  = 16;
    localparam int ENTRY_W  = SOCK_W + PRIO_W + PHOTO_W;
    localparam int SOCK_LSB  = 0;
    localparam int PRIO_LSB  = SOCK_W;
    localparam int PHOTO_LSB = SOCK_W + PRIO_W;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SCAN  = 5'b00010,
        ST_DRAIN = 5'b00100,
        ST_LOAD  = 5'b01000,
        ST_OUT   = 5'b10000
    } state_t;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
        logic scan_clr;
        logic load_out;
        logic last_out;
        logic first_round;
    } cmd_t;

endpackage

`default_nettype wire

// ===== rtl/bpfb_ctrl.sv =====
`default_nettype none

module bpfb_ctrl #(
    parameter int SLOTS = 8
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   s_tvalid,
    output logic                                        s_tready,
    output logic                                        m_tvalid,
    input  wire logic                                   m_tready,
    output bpfb_pkg::cmd_t                              cmd,
    output logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] wr_addr,
    output logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] rd_addr
);
    import bpfb_pkg::*;

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

    state_t        state_reg, state_next;
    logic [IW-1:0] fill_reg, fill_next;
    logic [IW-1:0] scan_reg, scan_next;
    logic [IW-1:0] round_reg, round_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            fill_reg  <= '0;
            scan_reg  <= '0;
            round_reg <= '0;
        end else begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            scan_reg  <= scan_next;
            round_reg <= round_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        fill_next  = fill_reg;
        scan_next  = scan_reg;
        round_next = round_reg;
        cmd        = '0;
        cmd.first_round = (round_reg == '0);
        cmd.last_out    = (round_reg == LAST_IDX);
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.wr_en = 1'b1;
                    if (fill_reg == LAST_IDX) begin
                        fill_next  = '0;
                        scan_next  = '0;
                        round_next = '0;
                        state_next = ST_SCAN;
                    end else begin
                        fill_next = fill_reg + IW'(1);
                    end
                end
            end
            ST_SCAN: begin
                cmd.rd_en    = 1'b1;
                // best candidate restarts with the first read of a round
                cmd.scan_clr = (scan_reg == '0);
                if (scan_reg == LAST_IDX) begin
                    state_next = ST_DRAIN;
                end else begin
                    scan_next = scan_reg + IW'(1);
                end
            end
            ST_DRAIN: begin
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                cmd.load_out = 1'b1;
                state_next   = ST_OUT;
            end
            ST_OUT: begin
                if (m_tready) begin
                    if (round_reg == LAST_IDX) begin
                        state_next = ST_IDLE;
                    end else begin
                        round_next = round_reg + IW'(1);
                        scan_next  = '0;
                        state_next = ST_SCAN;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);
    assign wr_addr  = fill_reg;
    assign rd_addr  = scan_reg;

endmodule

`default_nettype wire

// ===== rtl/bpfb_datapath.sv =====
`default_nettype none

module bpfb_datapath #(
    parameter int SLOTS = 8
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire bpfb_pkg::cmd_t                         cmd,
    input  wire logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] wr_addr,
    input  wire logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] rd_addr,
    input  wire logic [bpfb_pkg::ENTRY_W-1:0]           wr_data,
    output logic [bpfb_pkg::ENTRY_W-1:0]                out_data,
    output logic                                        out_last
);
    import bpfb_pkg::*;

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int KW = PRIO_W + IW;

    logic [ENTRY_W-1:0] entry_mem [0:SLOTS-1];

    logic [ENTRY_W-1:0] rd_data_reg;
    logic [IW-1:0]      rd_idx_reg;
    logic               rd_vld_reg;

    logic               best_found_reg;
    logic [KW-1:0]      best_key_reg;
    logic [ENTRY_W-1:0] best_data_reg;
    logic [KW-1:0]      last_key_reg;

    logic [ENTRY_W-1:0] out_data_reg;
    logic               out_last_reg;

    logic [KW-1:0]      cand_key;
    logic               cand_ok;
    logic               cand_better;

    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            entry_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.rd_en) begin
            rd_data_reg <= entry_mem[rd_addr];
        end
        rd_idx_reg <= rd_addr;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_vld_reg <= 1'b0;
        end else begin
            rd_vld_reg <= cmd.rd_en;
        end
    end

    // key orders by priority, then earlier slot first; keys of one batch are distinct
    assign cand_key    = {rd_data_reg[PRIO_LSB +: PRIO_W], ~rd_idx_reg};
    assign cand_ok     = cmd.first_round || (cand_key < last_key_reg);
    assign cand_better = !best_found_reg || (cand_key > best_key_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            best_found_reg <= 1'b0;
        end else if (cmd.scan_clr) begin
            best_found_reg <= 1'b0;
        end else if (rd_vld_reg && cand_ok && cand_better) begin
            best_found_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!cmd.scan_clr && rd_vld_reg && cand_ok && cand_better) begin
            best_key_reg  <= cand_key;
            best_data_reg <= rd_data_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_data_reg <= best_data_reg;
            out_last_reg <= cmd.last_out;
            last_key_reg <= best_key_reg;
        end
    end

    assign out_data = out_data_reg;
    assign out_last = out_last_reg;

endmodule

`default_nettype wire

// ===== rtl/batch_priority_flush_buffer.sv =====
// Collects requests into a store of SLOTS entries and, on the request that
// fills it, sends the whole batch out in descending priority order, equal
// priorities in arrival order, with m_tlast on the final item of the batch.
// Inserts that do not fill the store produce nothing.
// During a flush s_tready stays low; each output item costs one scan of the
// store through the single read port of the entry memory, plus any wait on
// m_tready.
`default_nettype none

module batch_priority_flush_buffer #(
    parameter int SLOTS = 8
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // socket_id [15:0], prio [23:16], photo_id [39:24]
    input  wire logic [39:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // out_socket [15:0], out_prio [23:16], out_photo [39:24]
    output logic [39:0]      m_tdata,
    output logic             m_tlast
);
    import bpfb_pkg::*;

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    cmd_t          cmd;
    logic [IW-1:0] wr_addr;
    logic [IW-1:0] rd_addr;

    bpfb_ctrl #(
        .SLOTS (SLOTS)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .wr_addr  (wr_addr),
        .rd_addr  (rd_addr)
    );

    bpfb_datapath #(
        .SLOTS (SLOTS)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .wr_addr  (wr_addr),
        .rd_addr  (rd_addr),
        .wr_data  (s_tdata),
        .out_data (m_tdata),
        .out_last (m_tlast)
    );

endmodule

`default_nettype wire

// ===== rtl/bpfb_checker.sv =====
`default_nettype none

`include "batch_priority_flush_buffer_assert.svh"

module bpfb_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [39:0] m_tdata,
    input wire logic        m_tlast
);

    // a stalled item holds
    `BPFB_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable({m_tdata, m_tlast}))

    // no insert is taken while an output item of a flush is offered
    `BPFB_ASSERT_SAME(a_no_overlap, m_tvalid, !s_tready)

    // the last item of a batch hands control back to the input side
    `BPFB_ASSERT_NEXT(a_last_idle, m_tvalid && m_tready && m_tlast, s_tready && !m_tvalid)

    // reset leaves the block idle and empty
    `BPFB_ASSERT_NEXT_ALWAYS(a_reset_idle, !aresetn, s_tready && !m_tvalid)

endmodule

bind batch_priority_flush_buffer bpfb_checker u_bpfb_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire
